/* rtl/json_string_unescape_utf8_core_macros.svh */
// assertion helpers used by the checker
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define JSU_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define JSU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define JSU_ASSERT_NEXT_ALWAYS(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
package jsu_pkg;

  localparam int LENGTH_WIDTH = 10;
  localparam int CNT_W        = LENGTH_WIDTH + 1;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-3:0] REG_MAX_LENGTH = '0;

  localparam logic [LENGTH_WIDTH-1:0] MAX_LENGTH_RST = LENGTH_WIDTH'(64);

  // result status codes
  localparam logic [1:0] ST_DATA   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_HEX1 = 3'd3,
    M_SBS  = 3'd4,
    M_SU   = 3'd5,
    M_HEX2 = 3'd6
  } mode_t;

  // one queued command: up to four result words of one input byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic [1:0]      status;
  } cmd_t;

endpackage

/* rtl/jsu_ifs.sv */
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       input_ended;

  modport source (output valid, output data_byte, output input_ended, input ready);
  modport sink (input valid, input data_byte, input input_ended, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output out_byte, output status, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input status, input last_of_run,
                output ready);
endinterface

/* rtl/jsu_fifo.sv */
module jsu_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jsu_pkg::cmd_t  push_data,
  input  logic           pop,
  output jsu_pkg::cmd_t  pop_data,
  output logic           full,
  output logic           empty
);
  import jsu_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/jsu_front.sv */
module jsu_front (
  input  logic                              clk,
  input  logic                              rst_n,
  jsu_in_if.sink                            in_if,
  input  logic [jsu_pkg::LENGTH_WIDTH-1:0]  max_length,
  input  logic                              q_full,
  output logic                              q_push,
  output jsu_pkg::cmd_t                     q_data
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HX = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CTRL_LIM = 8'h20;

  localparam logic [7:0] BS_CODE = 8'h08;
  localparam logic [7:0] FF_CODE = 8'h0c;

  localparam logic [15:0] HI_SUR_LO = 16'hd800;
  localparam logic [15:0] HI_SUR_HI = 16'hdbff;
  localparam logic [15:0] LO_SUR_LO = 16'hdc00;
  localparam logic [15:0] LO_SUR_HI = 16'hdfff;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [20:0] LIM_1B = 21'h7f;
  localparam logic [20:0] LIM_2B = 21'h7ff;
  localparam logic [20:0] LIM_3B = 21'hffff;
  localparam logic [7:0]  LEAD2  = 8'hc0;
  localparam logic [7:0]  LEAD3  = 8'he0;
  localparam logic [7:0]  LEAD4  = 8'hf0;
  localparam logic [7:0]  CONT   = 8'h80;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[CH_0:CH_9]}) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c inside {[CH_LA:CH_LF_HX]}) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  function automatic cmd_t utf8_enc(input logic [20:0] cp);
    cmd_t r;
    r.bytes  = '0;
    r.status = ST_DATA;
    if (cp <= LIM_1B) begin
      r.bytes[0] = cp[7:0];
      r.last_idx = 2'd0;
    end else if (cp <= LIM_2B) begin
      r.bytes[0] = LEAD2 | {3'b0, cp[10:6]};
      r.bytes[1] = CONT | {2'b0, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp <= LIM_3B) begin
      r.bytes[0] = LEAD3 | {4'b0, cp[15:12]};
      r.bytes[1] = CONT | {2'b0, cp[11:6]};
      r.bytes[2] = CONT | {2'b0, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = LEAD4 | {5'b0, cp[20:18]};
      r.bytes[1] = CONT | {2'b0, cp[17:12]};
      r.bytes[2] = CONT | {2'b0, cp[11:6]};
      r.bytes[3] = CONT | {2'b0, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

  mode_t             mode_r, mode_nxt;
  logic [1:0]        hex_cnt_r, hex_cnt_nxt;
  logic [9:0]        hi_r, hi_nxt;     // low ten bits of the high surrogate
  logic [11:0]       quad_r, quad_nxt; // hex digits gathered so far
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [7:0]        c;
  logic [4:0]        hv;
  logic [15:0]       qv;
  logic [20:0]       pair_cp;
  cmd_t              em_cmd;
  logic [CNT_W-1:0]  len_sum;
  logic              accept;
  logic              do_emit, do_reject, do_done;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    c       = in_if.data_byte;
    hv      = hex_val(c);
    qv      = {quad_r, hv[3:0]};
    pair_cp = SUPP_BASE + {1'b0, hi_r, qv[9:0]};

    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    hi_nxt      = hi_r;
    quad_nxt    = quad_r;
    cnt_nxt     = cnt_r;
    // raw string bytes pass through as one word
    em_cmd      = '{bytes: {24'h0, c}, last_idx: 2'd0, status: ST_DATA};
    do_emit     = 1'b0;
    do_reject   = 1'b0;
    do_done     = 1'b0;

    if (in_if.input_ended) begin
      do_reject = 1'b1;
    end else begin
      case (mode_r)
        M_STR: begin
          if (c == CH_QUOTE) begin
            do_done = 1'b1;
          end else if (c < CTRL_LIM) begin
            do_reject = 1'b1;
          end else if (c == CH_BSL) begin
            mode_nxt = M_ESC;
          end else begin
            do_emit = 1'b1;
          end
        end
        M_ESC: begin
          mode_nxt = M_STR;
          do_emit  = 1'b1;
          case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: em_cmd = utf8_enc({13'b0, c});
            CH_B:    em_cmd = utf8_enc({13'b0, BS_CODE});
            CH_F:    em_cmd = utf8_enc({13'b0, FF_CODE});
            CH_N:    em_cmd = utf8_enc({13'b0, CH_LF});
            CH_R:    em_cmd = utf8_enc({13'b0, CH_CR});
            CH_T:    em_cmd = utf8_enc({13'b0, CH_TAB});
            CH_U: begin
              do_emit     = 1'b0;
              mode_nxt    = M_HEX1;
              hex_cnt_nxt = '0;
              quad_nxt    = '0;
            end
            default: begin
              do_emit   = 1'b0;
              do_reject = 1'b1;
            end
          endcase
        end
        M_HEX1, M_HEX2: begin
          if (!hv[4]) begin
            do_reject = 1'b1;
          end else begin
            quad_nxt = qv[11:0];
            if (hex_cnt_r != 2'd3) begin
              hex_cnt_nxt = hex_cnt_r + 2'd1;
            end else begin
              hex_cnt_nxt = '0;
              if (mode_r == M_HEX1) begin
                if (qv >= HI_SUR_LO && qv <= HI_SUR_HI) begin
                  hi_nxt   = qv[9:0];
                  mode_nxt = M_SBS;
                end else if (qv >= LO_SUR_LO && qv <= LO_SUR_HI) begin
                  do_reject = 1'b1;
                end else begin
                  mode_nxt = M_STR;
                  em_cmd   = utf8_enc({5'b0, qv});
                  do_emit  = 1'b1;
                end
              end else if (qv < LO_SUR_LO || qv > LO_SUR_HI) begin
                do_reject = 1'b1;
              end else begin
                mode_nxt = M_STR;
                em_cmd   = utf8_enc(pair_cp);
                do_emit  = 1'b1;
              end
            end
          end
        end
        M_SBS: begin
          if (c != CH_BSL) begin
            do_reject = 1'b1;
          end else begin
            mode_nxt = M_SU;
          end
        end
        M_SU: begin
          if (c != CH_U) begin
            do_reject = 1'b1;
          end else begin
            mode_nxt    = M_HEX2;
            hex_cnt_nxt = '0;
            quad_nxt    = '0;
          end
        end
        default: begin
          if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
            mode_nxt = mode_r;
          end else if (c == CH_QUOTE) begin
            mode_nxt    = M_STR;
            hex_cnt_nxt = '0;
            hi_nxt      = '0;
            quad_nxt    = '0;
            cnt_nxt     = '0;
          end else begin
            do_reject = 1'b1;
          end
        end
      endcase
    end

    // length limit: the whole item is rejected when its bytes do not fit
    len_sum = cnt_r + CNT_W'({1'b0, em_cmd.last_idx} + 3'd1);
    if (do_emit && (len_sum > {1'b0, max_length})) begin
      do_emit   = 1'b0;
      do_reject = 1'b1;
    end
    if (do_emit) begin
      cnt_nxt = len_sum;
    end
    if (do_reject || do_done) begin
      mode_nxt    = M_IDLE;
      hex_cnt_nxt = '0;
      hi_nxt      = '0;
      quad_nxt    = '0;
      cnt_nxt     = '0;
    end

    if (do_emit) begin
      q_data = em_cmd;
    end else begin
      q_data.bytes    = '0;
      q_data.last_idx = 2'd0;
      q_data.status   = do_done ? ST_DONE : ST_REJECT;
    end
    q_push = accept && (do_emit || do_reject || do_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      hex_cnt_r <= '0;
      hi_r      <= '0;
      quad_r    <= '0;
      cnt_r     <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      hi_r      <= hi_nxt;
      quad_r    <= quad_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

/* rtl/jsu_back.sv */
module jsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  jsu_pkg::cmd_t  q_data,
  output logic           q_pop,
  jsu_out_if.source      out_if
);
  import jsu_pkg::*;

  cmd_t       cur_r, cur_nxt;
  logic       cur_vld_r, cur_vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       fire, last_word;

  assign out_if.valid       = cur_vld_r;
  assign out_if.out_byte    = cur_r.bytes[idx_r];
  assign out_if.status      = cur_r.status;
  assign last_word          = (idx_r == cur_r.last_idx);
  assign out_if.last_of_run = last_word;

  assign fire  = out_if.valid && out_if.ready;
  assign q_pop = !q_empty && (!cur_vld_r || (fire && last_word));

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (q_pop) begin
      cur_nxt     = q_data;
      cur_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (fire && last_word) begin
      cur_vld_nxt = 1'b0;
      idx_nxt     = '0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule

/* rtl/json_string_unescape_utf8_core.sv */
// channel   | dir | handshake          | word
// ----------+-----+--------------------+-----------------------------------
// in_if     | in  | valid/ready        | data_byte[7:0], input_ended
// out_if    | out | valid/ready        | out_byte[7:0], status[1:0], last_of_run
// apb       | in  | psel/penable/pwrite| max_length at byte address 0
//
// one input byte is taken per cycle; it yields zero to four result words,
// sent one per cycle unless out_if stalls, via the queue and the output stage.
// a four-entry command queue sits between the parser and the output stage,
// so in_if.ready drops only while that queue is full.
// rst_n is synchronous: parser goes idle, queue empties, max_length = 64.
module json_string_unescape_utf8_core (
  input  logic                              clk,
  input  logic                              rst_n,
  jsu_in_if.sink                            in_if,
  jsu_out_if.source                         out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [jsu_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [jsu_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [jsu_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import jsu_pkg::*;

  logic [LENGTH_WIDTH-1:0] max_len_r, max_len_nxt;
  logic                    reg_hit;
  logic                    q_push, q_pop, q_full, q_empty;
  cmd_t                    q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_MAX_LENGTH);
  assign prdata  = reg_hit ? CFG_DATA_W'(max_len_r) : '0;

  always_comb begin
    max_len_nxt = max_len_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      max_len_nxt = pwdata[LENGTH_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LENGTH_RST;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .max_length (max_len_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  jsu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

/* rtl/jsu_checker.sv */
`include "json_string_unescape_utf8_core_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] status,
  input logic       last_of_run
);
  import jsu_pkg::*;

  // a stalled word holds its value
  `JSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(status) && $stable(last_of_run), "stalled result word changed")

  // done and reject are lone words with a zero byte
  `JSU_ASSERT_NOW(a_status_single, out_valid && status != ST_DATA, last_of_run && out_byte == 8'h00, "done or reject word not alone")

  // the rest of a run follows without a gap
  `JSU_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !last_of_run, out_valid && status == ST_DATA, "gap inside a multi-byte run")

  // reset leaves no result pending
  `JSU_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_byte    (out_if.out_byte),
  .status      (out_if.status),
  .last_of_run (out_if.last_of_run)
);
